// File: rtl/vfc_pkg.sv
// Shared types, widths and constants of the view frustum cull core.
// No dependencies; every other file of the block refers to this package by scoped names.
package vfc_pkg;

	localparam int COORD_W     = 20;               // Q16.4 coordinates and depths
	localparam int COEF_W      = 16;               // Q2.14 axes and normals
	localparam int RAD_W       = 19;               // unsigned Q15.4 radius
	localparam int VIEW_W      = 40;               // view coordinates, 18 fraction bits
	localparam int PROD_W      = VIEW_W + COEF_W;  // one product of the multiply-add unit
	localparam int SUM_W       = PROD_W + 2;       // sum of three products and a bias
	localparam int DEPTH_W     = 42;               // depth compares, 18 fraction bits
	localparam int MODE_W      = 2;
	localparam int FLAG_W      = 4;
	localparam int IN_DATA_W   = 80;
	localparam int OUT_DATA_W  = 8;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;

	localparam int BOX_CORNERS = 8;
	localparam int CORNER_W    = $clog2(BOX_CORNERS);

	localparam logic [47:0] AXIS_RIGHT_RST  = 48'd16384;
	localparam logic [47:0] AXIS_UP_RST     = 48'd1073741824;
	localparam logic [47:0] AXIS_AT_RST     = 48'd70368744177664;
	localparam logic [59:0] TRANSLATION_RST = 60'd0;
	localparam logic [39:0] CLIP_DEPTHS_RST = 40'd33554432016;

	typedef enum logic [MODE_W-1:0] {
		MODE_POINT  = 2'd0,
		MODE_SPHERE = 2'd1,
		MODE_BOX    = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_AXIS_RIGHT       = 3'd0,
		REG_AXIS_UP          = 3'd1,
		REG_AXIS_AT          = 3'd2,
		REG_TRANSLATION      = 3'd3,
		REG_CLIP_DEPTHS      = 3'd4,
		REG_SIDE_NORMALS     = 3'd5,
		REG_VERTICAL_NORMALS = 3'd6
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_STEP1  = 6'b000010,
		ST_STEP2  = 6'b000100,
		ST_STEP3  = 6'b001000,
		ST_STEP4  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic step1;
		logic step2;
		logic step3;
		logic step4;
		logic finish;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_unused;
		logic out_stall;
	} ctrl_sts_t;

endpackage

// File: rtl/vfc_dot3.sv
// Three-term signed multiply-add unit: a0*b0 + a1*b1 + a2*b2 + bias.
// Depends on vfc_pkg for widths. Shared by the transform and plane steps.
module vfc_dot3 (
	input  logic signed [vfc_pkg::VIEW_W-1:0] a0,
	input  logic signed [vfc_pkg::VIEW_W-1:0] a1,
	input  logic signed [vfc_pkg::VIEW_W-1:0] a2,
	input  logic signed [vfc_pkg::COEF_W-1:0] b0,
	input  logic signed [vfc_pkg::COEF_W-1:0] b1,
	input  logic signed [vfc_pkg::COEF_W-1:0] b2,
	input  logic signed [vfc_pkg::SUM_W-1:0]  bias,
	output logic signed [vfc_pkg::SUM_W-1:0]  sum
);

	logic signed [vfc_pkg::PROD_W-1:0] p0, p1, p2;

	assign p0 = a0 * b0;
	assign p1 = a1 * b1;
	assign p2 = a2 * b2;

	assign sum = vfc_pkg::SUM_W'(p0) + vfc_pkg::SUM_W'(p1) + vfc_pkg::SUM_W'(p2) + bias;

endmodule

// File: rtl/vfc_ctrl.sv
// Sequencer of the view frustum cull core: one-hot state machine issuing step commands.
// Depends on vfc_pkg for the state, command and status types.
module vfc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  vfc_pkg::ctrl_sts_t    sts,
	output vfc_pkg::ctrl_cmd_t    cmd
);

	vfc_pkg::state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			vfc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					// An item of the unused kind is taken and dropped.
					if (!sts.in_unused) begin
						state_nxt = vfc_pkg::ST_STEP1;
					end
				end
			end
			vfc_pkg::ST_STEP1: begin
				cmd.step1 = 1'b1;
				state_nxt = vfc_pkg::ST_STEP2;
			end
			vfc_pkg::ST_STEP2: begin
				cmd.step2 = 1'b1;
				state_nxt = vfc_pkg::ST_STEP3;
			end
			vfc_pkg::ST_STEP3: begin
				cmd.step3 = 1'b1;
				state_nxt = vfc_pkg::ST_STEP4;
			end
			vfc_pkg::ST_STEP4: begin
				cmd.step4 = 1'b1;
				state_nxt = vfc_pkg::ST_FINISH;
			end
			vfc_pkg::ST_FINISH: begin
				if (!sts.out_stall) begin
					cmd.finish = 1'b1;
					state_nxt  = vfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = vfc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_finish_not_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_stall)
		else $error("finish issued while the result register is still occupied");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == vfc_pkg::ST_IDLE)
		else $error("input loaded outside the idle state");

	a_step4_then_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfc_pkg::ST_STEP4 |=> state_q == vfc_pkg::ST_FINISH)
		else $error("last multiply step not followed by the finish state");

endmodule

// File: rtl/vfc_datapath.sv
// Datapath of the view frustum cull core: configuration registers, operand registers,
// two shared multiply-add units, plane tests, box state and the result register.
// Depends on vfc_pkg and vfc_dot3.
module vfc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [vfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [vfc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic [vfc_pkg::MODE_W-1:0]          in_mode,
	input  logic signed [vfc_pkg::COORD_W-1:0]  in_pos_x,
	input  logic signed [vfc_pkg::COORD_W-1:0]  in_pos_y,
	input  logic signed [vfc_pkg::COORD_W-1:0]  in_pos_z,
	input  logic [vfc_pkg::RAD_W-1:0]           in_radius,
	input  vfc_pkg::ctrl_cmd_t                  cmd,
	output vfc_pkg::ctrl_sts_t                  sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                out_visible
);

	// Configuration registers.
	logic [47:0] axis_right_q, axis_up_q, axis_at_q;
	logic [59:0] translation_q;
	logic [39:0] clip_depths_q;
	logic [63:0] side_normals_q, vertical_normals_q;

	// Item registers.
	logic [vfc_pkg::MODE_W-1:0]         mode_q;
	logic signed [vfc_pkg::COORD_W-1:0] x_q, y_q, z_q;
	logic [vfc_pkg::RAD_W-1:0]          radius_q;

	// Step results.
	logic signed [vfc_pkg::VIEW_W-1:0] vx_q, vy_q, vz_q;
	logic signed [vfc_pkg::SUM_W-1:0]  d0_q, d1_q, d2_q, d3_q;

	// Box state and result register.
	logic [vfc_pkg::CORNER_W-1:0] corner_q;
	logic [vfc_pkg::FLAG_W-1:0]   flags_q;
	logic                         out_valid_q, out_visible_q;

	localparam logic [vfc_pkg::CORNER_W-1:0] LAST_CORNER =
		vfc_pkg::CORNER_W'(vfc_pkg::BOX_CORNERS - 1);

	function automatic logic signed [vfc_pkg::COEF_W-1:0] half16(
		input logic [63:0] r, input int unsigned k);
		return $signed(r[16*k +: 16]);
	endfunction

	function automatic logic signed [vfc_pkg::COORD_W-1:0] field20(
		input logic [59:0] r, input int unsigned k);
		return $signed(r[20*k +: 20]);
	endfunction

	// Q16.4 value moved to 18 fraction bits.
	function automatic logic signed [vfc_pkg::SUM_W-1:0] q4_to_q18(
		input logic signed [vfc_pkg::COORD_W-1:0] v);
		return vfc_pkg::SUM_W'($signed({v, 14'b0}));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_right_q       <= vfc_pkg::AXIS_RIGHT_RST;
			axis_up_q          <= vfc_pkg::AXIS_UP_RST;
			axis_at_q          <= vfc_pkg::AXIS_AT_RST;
			translation_q      <= vfc_pkg::TRANSLATION_RST;
			clip_depths_q      <= vfc_pkg::CLIP_DEPTHS_RST;
			side_normals_q     <= '0;
			vertical_normals_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				vfc_pkg::REG_AXIS_RIGHT:       axis_right_q       <= cfg_wdata[47:0];
				vfc_pkg::REG_AXIS_UP:          axis_up_q          <= cfg_wdata[47:0];
				vfc_pkg::REG_AXIS_AT:          axis_at_q          <= cfg_wdata[47:0];
				vfc_pkg::REG_TRANSLATION:      translation_q      <= cfg_wdata[59:0];
				vfc_pkg::REG_CLIP_DEPTHS:      clip_depths_q      <= cfg_wdata[39:0];
				vfc_pkg::REG_SIDE_NORMALS:     side_normals_q     <= cfg_wdata;
				vfc_pkg::REG_VERTICAL_NORMALS: vertical_normals_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= in_mode;
			x_q      <= in_pos_x;
			y_q      <= in_pos_y;
			z_q      <= in_pos_z;
			radius_q <= in_radius;
		end
	end

	// Operand selection for the two multiply-add units.
	logic signed [vfc_pkg::VIEW_W-1:0] a_a0, a_a1, a_a2, b_a0, b_a1, b_a2;
	logic signed [vfc_pkg::COEF_W-1:0] a_b0, a_b1, a_b2, b_b0, b_b1, b_b2;
	logic signed [vfc_pkg::SUM_W-1:0]  a_bias, b_bias, sum_a, sum_b;
	logic signed [vfc_pkg::VIEW_W-1:0] xe, ye, ze;

	assign xe = vfc_pkg::VIEW_W'(x_q);
	assign ye = vfc_pkg::VIEW_W'(y_q);
	assign ze = vfc_pkg::VIEW_W'(z_q);

	always_comb begin
		a_a0 = '0; a_a1 = '0; a_a2 = '0; a_b0 = '0; a_b1 = '0; a_b2 = '0; a_bias = '0;
		b_a0 = '0; b_a1 = '0; b_a2 = '0; b_b0 = '0; b_b1 = '0; b_b2 = '0; b_bias = '0;
		priority if (cmd.step1) begin
			// View x and view y.
			a_a0 = xe; a_a1 = ye; a_a2 = ze;
			a_b0 = half16(64'(axis_right_q), 0);
			a_b1 = half16(64'(axis_up_q), 0);
			a_b2 = half16(64'(axis_at_q), 0);
			a_bias = q4_to_q18(field20(translation_q, 0));
			b_a0 = xe; b_a1 = ye; b_a2 = ze;
			b_b0 = half16(64'(axis_right_q), 1);
			b_b1 = half16(64'(axis_up_q), 1);
			b_b2 = half16(64'(axis_at_q), 1);
			b_bias = q4_to_q18(field20(translation_q, 1));
		end else if (cmd.step2) begin
			// View z and side plane 0.
			a_a0 = xe; a_a1 = ye; a_a2 = ze;
			a_b0 = half16(64'(axis_right_q), 2);
			a_b1 = half16(64'(axis_up_q), 2);
			a_b2 = half16(64'(axis_at_q), 2);
			a_bias = q4_to_q18(field20(translation_q, 2));
			b_a0 = vx_q; b_a1 = vy_q;
			b_b0 = half16(side_normals_q, 0);
			b_b1 = half16(side_normals_q, 1);
		end else if (cmd.step3) begin
			// Side plane 1 and vertical plane 2.
			a_a0 = vx_q; a_a1 = vy_q;
			a_b0 = half16(side_normals_q, 2);
			a_b1 = half16(side_normals_q, 3);
			b_a0 = vy_q; b_a1 = vz_q;
			b_b0 = half16(vertical_normals_q, 0);
			b_b1 = half16(vertical_normals_q, 1);
		end else if (cmd.step4) begin
			// Vertical plane 3.
			a_a0 = vy_q; a_a1 = vz_q;
			a_b0 = half16(vertical_normals_q, 2);
			a_b1 = half16(vertical_normals_q, 3);
		end
	end

	vfc_dot3 u_dot_a (
		.a0(a_a0), .a1(a_a1), .a2(a_a2),
		.b0(a_b0), .b1(a_b1), .b2(a_b2),
		.bias(a_bias), .sum(sum_a)
	);

	vfc_dot3 u_dot_b (
		.a0(b_a0), .a1(b_a1), .a2(b_a2),
		.b0(b_b0), .b1(b_b1), .b2(b_b2),
		.bias(b_bias), .sum(sum_b)
	);

	always_ff @(posedge clk) begin
		if (cmd.step1) begin
			vx_q <= sum_a[vfc_pkg::VIEW_W-1:0];
			vy_q <= sum_b[vfc_pkg::VIEW_W-1:0];
		end
		if (cmd.step2) begin
			vz_q <= sum_a[vfc_pkg::VIEW_W-1:0];
			d0_q <= sum_b;
		end
		if (cmd.step3) begin
			d1_q <= sum_a;
			d2_q <= sum_b;
		end
		if (cmd.step4) begin
			d3_q <= sum_a;
		end
	end

	// Plane tests, evaluated in the finish cycle.
	logic [vfc_pkg::RAD_W-1:0]          r_eff;
	logic signed [vfc_pkg::DEPTH_W-1:0] vy_e, near_e, far_e, rad18, vy_plus, vy_minus;
	logic signed [vfc_pkg::SUM_W-1:0]   rad32;
	logic                               sphere_vis, box_last, produce, box_vis;
	logic [vfc_pkg::FLAG_W-1:0]         outside, flags_nxt;

	assign r_eff    = (mode_q == vfc_pkg::MODE_SPHERE) ? radius_q : '0;
	assign vy_e     = vfc_pkg::DEPTH_W'(vy_q);
	assign near_e   = vfc_pkg::DEPTH_W'($signed({field20(60'(clip_depths_q), 0), 14'b0}));
	assign far_e    = vfc_pkg::DEPTH_W'($signed({field20(60'(clip_depths_q), 1), 14'b0}));
	assign rad18    = $signed(vfc_pkg::DEPTH_W'({r_eff, 14'b0}));
	assign rad32    = $signed(vfc_pkg::SUM_W'({r_eff, 28'b0}));
	assign vy_plus  = vy_e + rad18;
	assign vy_minus = vy_e - rad18;

	assign sphere_vis = !(vy_plus < near_e) && !(vy_minus > far_e) &&
		!(d0_q > rad32) && !(d1_q > rad32) && !(d2_q > rad32) && !(d3_q > rad32);

	assign outside[0] = vy_e < near_e;
	assign outside[1] = vy_e > far_e;
	assign outside[2] = !d0_q[vfc_pkg::SUM_W-1] && (|d0_q);
	assign outside[3] = !d1_q[vfc_pkg::SUM_W-1] && (|d1_q);
	assign flags_nxt  = flags_q & outside;
	assign box_last   = corner_q == LAST_CORNER;
	assign box_vis    = flags_nxt == '0;
	assign produce    = (mode_q != vfc_pkg::MODE_BOX) || box_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q    <= '0;
			flags_q     <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish && mode_q == vfc_pkg::MODE_BOX) begin
				if (box_last) begin
					corner_q <= '0;
					flags_q  <= '1;
				end else begin
					corner_q <= corner_q + 1'b1;
					flags_q  <= flags_nxt;
				end
			end
			if (cmd.finish && produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && produce) begin
			out_visible_q <= (mode_q == vfc_pkg::MODE_BOX) ? box_vis : sphere_vis;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_visible   = out_visible_q;
	assign sts.in_unused = in_mode == vfc_pkg::MODE_UNUSED;
	assign sts.out_stall = out_valid_q && !out_ready;

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result appeared without a finish command");

	a_box_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && mode_q == vfc_pkg::MODE_BOX && box_last |=> corner_q == '0 && flags_q == '1)
		else $error("box state not returned to its start after the last corner");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_visible_q))
		else $error("waiting result dropped or changed before it was taken");

endmodule

// File: rtl/view_frustum_cull_core.sv
// Top level of the view frustum cull core: stream ports, configuration port and wiring.
// Depends on vfc_pkg, vfc_ctrl, vfc_datapath and vfc_dot3.

// The core takes one point, sphere or box corner per input transaction, moves it into view
// space with the programmed axes and translation, and tests it against the near and far
// depths and the frustum planes, a box corner against side planes 0 and 1 only. A point or sphere
// gives one result transaction straight away; a box is sent as eight corner transactions and
// gives one result after the last corner. An item of the unused kind is accepted and dropped
// without a result. Every other item goes from the accept state through four steps through two
// shared three-term multiply-add units (view x and y, then view z and side plane 0, then side
// plane 1 and vertical plane 2, then vertical plane 3) and a finish state that evaluates the
// tests and loads the result register. The result register lets the core work on the next item
// while a result waits; the finish cycle only waits if the previous result is still pending.
// Configuration registers may be written only while the core is idle.
module view_frustum_cull_core (
	input  logic                                 clk,
	input  logic                                 arst_n,

	// Configuration write port: register index as in the register list.
	input  logic                                 cfg_wen,
	input  logic [vfc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [vfc_pkg::CFG_DATA_W-1:0]       cfg_wdata,

	// Input stream.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tdata from bit 0: pos_x[19:0], pos_y[39:20], pos_z[59:40], radius[78:60], zero pad.
	input  logic [vfc_pkg::IN_DATA_W-1:0]        s_tdata,
	// tuser from bit 0: mode[1:0].
	input  logic [vfc_pkg::MODE_W-1:0]           s_tuser,

	// Result stream.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tdata from bit 0: visible[0], zero pad.
	output logic [vfc_pkg::OUT_DATA_W-1:0]       m_tdata
);

	vfc_pkg::ctrl_cmd_t cmd;
	vfc_pkg::ctrl_sts_t sts;
	logic               visible;

	// The sequencer owns the input handshake; the datapath owns the result register.
	vfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vfc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_mode     (s_tuser),
		.in_pos_x    ($signed(s_tdata[19:0])),
		.in_pos_y    ($signed(s_tdata[39:20])),
		.in_pos_z    ($signed(s_tdata[59:40])),
		.in_radius   (s_tdata[78:60]),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_visible (visible)
	);

	// The single result bit sits in the lowest bit of the byte.
	assign m_tdata = {{(vfc_pkg::OUT_DATA_W-1){1'b0}}, visible};

endmodule
